FILE: rtl/issp_pkg.sv
package issp_pkg;

  // default universe size and fixed field widths
  localparam int UNIVERSE_DEF = 256;
  localparam int WORD_W       = 16;
  localparam int KEY_W        = 16;
  localparam int ANS_W        = 8;

  // operation codes carried in the kind field
  localparam logic [1:0] KIND_INSERT = 2'd0;
  localparam logic [1:0] KIND_SUCC   = 2'd1;
  localparam logic [1:0] KIND_PRED   = 2'd2;

  // input item
  typedef struct packed {
    logic [1:0]       kind;
    logic [KEY_W-1:0] key;
  } in_item_t;

  // result item
  typedef struct packed {
    logic [ANS_W-1:0] answer;
    logic             found;
    logic             out_of_range;
  } out_item_t;

  // sequencer states
  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_LOOK,
    ST_SUM,
    ST_TGT,
    ST_DONE
  } st_t;

  // address width of a memory of the given depth
  function automatic int addr_bits(input int depth);
    return (depth > 1) ? $clog2(depth) : 1;
  endfunction

  // bits strictly above position b
  function automatic logic [WORD_W-1:0] mask_above(input logic [3:0] b);
    logic [WORD_W-1:0] m;
    m = {WORD_W{1'b1}} << b;
    return m << 1;
  endfunction

  // bits strictly below position b
  function automatic logic [WORD_W-1:0] mask_below(input logic [3:0] b);
    logic [WORD_W-1:0] m;
    m = {WORD_W{1'b1}} << b;
    return ~m;
  endfunction

  // position of the lowest set bit, zero for an empty word
  function automatic logic [3:0] lowest_bit(input logic [WORD_W-1:0] v);
    logic [3:0] r;
    r = '0;
    for (int i = WORD_W - 1; i >= 0; i--) begin
      if (v[i]) r = 4'(i);
    end
    return r;
  endfunction

  // position of the highest set bit, zero for an empty word
  function automatic logic [3:0] highest_bit(input logic [WORD_W-1:0] v);
    logic [3:0] r;
    r = '0;
    for (int i = 0; i < WORD_W; i++) begin
      if (v[i]) r = 4'(i);
    end
    return r;
  endfunction

  // lowest bit for successor search, highest for predecessor search
  function automatic logic [3:0] pick_bit(input logic [WORD_W-1:0] v, input logic succ);
    return succ ? lowest_bit(v) : highest_bit(v);
  endfunction

endpackage

FILE: rtl/integer_set_successor_predecessor.sv
// Integer set over 0 .. UNIVERSE-1 with insert, successor (least member above
// the key) and predecessor (greatest member below the key). Membership lives in
// a RAM of 16-bit cluster words, a second RAM holds one bit per non-empty
// cluster, and the smallest and largest members sit in registers. One item is
// handled at a time. Out-of-range keys, unused kinds and queries settled by the
// smallest or largest member go from idle straight to done. Inserts (read, then
// write back both words), queries answered inside the key's own cluster and
// searches that stop at the end of the key's summary word pass through the look
// state. A query whose answer lies in another cluster also passes through the
// target state; either search visits the sum state once per further summary
// word scanned (there are ceil(UNIVERSE/256) of them). The output register
// takes the result, so the next item is accepted while a result still waits
// downstream; a second result waits inside the block until that register
// drains. After reset the block clears both RAMs, one cluster word a cycle,
// and stalls input meanwhile. Answers carry the low 8 bits of the member found.
module integer_set_successor_predecessor #(
  parameter int UNIVERSE = issp_pkg::UNIVERSE_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  input  issp_pkg::in_item_t   in_item,
  output logic                 in_stall,
  output logic                 out_valid,
  output issp_pkg::out_item_t  out_item,
  input  logic                 out_stall
);

  localparam int CLUSTERS  = (UNIVERSE + 15) / 16;
  localparam int SUM_WORDS = (CLUSTERS + 15) / 16;
  localparam int CAW       = issp_pkg::addr_bits(CLUSTERS);
  localparam int SAW       = issp_pkg::addr_bits(SUM_WORDS);

  logic                        cl_we;
  logic [CAW-1:0]              cl_addr;
  logic [issp_pkg::WORD_W-1:0] cl_wdata;
  logic [issp_pkg::WORD_W-1:0] cl_rdata;
  logic                        sm_we;
  logic [SAW-1:0]              sm_addr;
  logic [issp_pkg::WORD_W-1:0] sm_wdata;
  logic [issp_pkg::WORD_W-1:0] sm_rdata;
  logic                        res_valid;
  logic                        res_ready;
  issp_pkg::out_item_t         res_item;

  logic                        out_valid_r, out_valid_nxt;
  issp_pkg::out_item_t         out_item_r, out_item_nxt;

  // cluster words
  issp_ram #(
    .WIDTH(issp_pkg::WORD_W),
    .DEPTH(CLUSTERS)
  ) u_cluster_ram (
    .clk  (clk),
    .we   (cl_we),
    .addr (cl_addr),
    .wdata(cl_wdata),
    .rdata(cl_rdata)
  );

  // summary words, one bit per cluster
  issp_ram #(
    .WIDTH(issp_pkg::WORD_W),
    .DEPTH(SUM_WORDS)
  ) u_summary_ram (
    .clk  (clk),
    .we   (sm_we),
    .addr (sm_addr),
    .wdata(sm_wdata),
    .rdata(sm_rdata)
  );

  // read-modify-write sequencer
  issp_seq #(
    .UNIVERSE(UNIVERSE)
  ) u_seq (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_item  (in_item),
    .in_stall (in_stall),
    .res_valid(res_valid),
    .res_item (res_item),
    .res_ready(res_ready),
    .cl_we    (cl_we),
    .cl_addr  (cl_addr),
    .cl_wdata (cl_wdata),
    .cl_rdata (cl_rdata),
    .sm_we    (sm_we),
    .sm_addr  (sm_addr),
    .sm_wdata (sm_wdata),
    .sm_rdata (sm_rdata)
  );

  // output register: free when empty or drained this cycle
  assign res_ready = !out_valid_r || !out_stall;

  always_comb begin
    out_valid_nxt = out_valid_r;
    out_item_nxt  = out_item_r;
    if (res_valid && res_ready) begin
      out_valid_nxt = 1'b1;
      out_item_nxt  = res_item;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_item_r <= out_item_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

endmodule

FILE: rtl/issp_ram.sv
module issp_ram #(
  parameter int WIDTH = issp_pkg::WORD_W,
  parameter int DEPTH = 16
) (
  input  logic                                    clk,
  input  logic                                    we,
  input  logic [issp_pkg::addr_bits(DEPTH)-1:0]   addr,
  input  logic [WIDTH-1:0]                        wdata,
  output logic [WIDTH-1:0]                        rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // single port, read data registered (old contents on a write)
  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[addr] <= wdata;
    end
    rdata_r <= mem_r[addr];
  end

  assign rdata = rdata_r;

endmodule

FILE: rtl/issp_seq.sv
module issp_seq #(
  parameter int UNIVERSE = issp_pkg::UNIVERSE_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  input  issp_pkg::in_item_t            in_item,
  output logic                          in_stall,
  output logic                          res_valid,
  output issp_pkg::out_item_t           res_item,
  input  logic                          res_ready,
  output logic                          cl_we,
  output logic [issp_pkg::addr_bits((UNIVERSE + 15) / 16)-1:0] cl_addr,
  output logic [issp_pkg::WORD_W-1:0]   cl_wdata,
  input  logic [issp_pkg::WORD_W-1:0]   cl_rdata,
  output logic                          sm_we,
  output logic [issp_pkg::addr_bits((((UNIVERSE + 15) / 16) + 15) / 16)-1:0] sm_addr,
  output logic [issp_pkg::WORD_W-1:0]   sm_wdata,
  input  logic [issp_pkg::WORD_W-1:0]   sm_rdata
);

  localparam int CLUSTERS  = (UNIVERSE + 15) / 16;
  localparam int SUM_WORDS = (CLUSTERS + 15) / 16;
  localparam int CAW       = issp_pkg::addr_bits(CLUSTERS);
  localparam int SAW       = issp_pkg::addr_bits(SUM_WORDS);
  localparam logic [16:0]    UNI_LIM   = 17'(UNIVERSE);
  localparam logic [7:0]     LAST_WORD = 8'(SUM_WORDS - 1);
  localparam logic [CAW-1:0] LAST_CL   = CAW'(CLUSTERS - 1);
  localparam logic [12:0]    SUM_CNT   = 13'(SUM_WORDS);

  issp_pkg::st_t       state_r, state_nxt;
  logic [CAW-1:0]      clr_r, clr_nxt;
  logic [15:0]         key_r, key_nxt;
  logic [1:0]          kind_r, kind_nxt;
  logic [7:0]          w_r, w_nxt;
  logic [11:0]         tc_r, tc_nxt;
  issp_pkg::out_item_t res_r, res_nxt;
  logic [15:0]         min_r, min_nxt;
  logic [15:0]         max_r, max_nxt;
  logic                empty_r, empty_nxt;

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= issp_pkg::ST_CLEAR;
      clr_r   <= '0;
      min_r   <= '0;
      max_r   <= '0;
      empty_r <= 1'b1;
    end else begin
      state_r <= state_nxt;
      clr_r   <= clr_nxt;
      min_r   <= min_nxt;
      max_r   <= max_nxt;
      empty_r <= empty_nxt;
    end
  end

  // item registers
  always_ff @(posedge clk) begin
    key_r  <= key_nxt;
    kind_r <= kind_nxt;
    w_r    <= w_nxt;
    tc_r   <= tc_nxt;
    res_r  <= res_nxt;
  end

  // next state, memory accesses and handshakes
  always_comb begin
    logic                          succ;
    logic                          in_range;
    logic [issp_pkg::WORD_W-1:0]   cw_m;
    logic [issp_pkg::WORD_W-1:0]   sw_m;

    state_nxt = state_r;
    clr_nxt   = clr_r;
    key_nxt   = key_r;
    kind_nxt  = kind_r;
    w_nxt     = w_r;
    tc_nxt    = tc_r;
    res_nxt   = res_r;
    min_nxt   = min_r;
    max_nxt   = max_r;
    empty_nxt = empty_r;

    cl_we     = 1'b0;
    cl_addr   = in_item.key[4 +: CAW];
    cl_wdata  = '0;
    sm_we     = 1'b0;
    sm_addr   = in_item.key[8 +: SAW];
    sm_wdata  = '0;
    in_stall  = 1'b1;
    res_valid = 1'b0;

    succ     = (kind_r == issp_pkg::KIND_SUCC);
    in_range = {1'b0, in_item.key} < UNI_LIM;
    cw_m = cl_rdata & (succ ? issp_pkg::mask_above(key_r[3:0])
                            : issp_pkg::mask_below(key_r[3:0]));
    sw_m = sm_rdata & (succ ? issp_pkg::mask_above(key_r[7:4])
                            : issp_pkg::mask_below(key_r[7:4]));

    unique case (state_r)
      // sweep both memories to zero after reset
      issp_pkg::ST_CLEAR: begin
        cl_we   = 1'b1;
        cl_addr = clr_r;
        sm_we   = 13'(clr_r) < SUM_CNT;
        sm_addr = clr_r[SAW-1:0];
        if (clr_r == LAST_CL) begin
          state_nxt = issp_pkg::ST_IDLE;
        end else begin
          clr_nxt = clr_r + CAW'(1);
        end
      end

      // take an item, settle the trivial cases from min and max
      issp_pkg::ST_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) begin
          key_nxt   = in_item.key;
          kind_nxt  = in_item.kind;
          res_nxt   = '0;
          state_nxt = issp_pkg::ST_DONE;
          if (in_item.kind != issp_pkg::KIND_INSERT && in_item.kind != issp_pkg::KIND_SUCC &&
              in_item.kind != issp_pkg::KIND_PRED) begin
            res_nxt = '0;
          end else if (!in_range) begin
            res_nxt.out_of_range = 1'b1;
          end else begin
            unique case (in_item.kind)
              issp_pkg::KIND_INSERT: begin
                state_nxt = issp_pkg::ST_LOOK;
                empty_nxt = 1'b0;
                if (empty_r || in_item.key < min_r) min_nxt = in_item.key;
                if (empty_r || in_item.key > max_r) max_nxt = in_item.key;
              end
              issp_pkg::KIND_SUCC: begin
                priority if (empty_r) begin
                  res_nxt = '0;
                end else if (in_item.key < min_r) begin
                  res_nxt.found  = 1'b1;
                  res_nxt.answer = min_r[7:0];
                end else if (in_item.key >= max_r) begin
                  res_nxt = '0;
                end else begin
                  state_nxt = issp_pkg::ST_LOOK;
                end
              end
              issp_pkg::KIND_PRED: begin
                priority if (empty_r) begin
                  res_nxt = '0;
                end else if (in_item.key > max_r) begin
                  res_nxt.found  = 1'b1;
                  res_nxt.answer = max_r[7:0];
                end else if (in_item.key <= min_r) begin
                  res_nxt = '0;
                end else begin
                  state_nxt = issp_pkg::ST_LOOK;
                end
              end
              default: begin
                res_nxt = '0;
              end
            endcase
          end
        end
      end

      // key's cluster word and summary word are here
      issp_pkg::ST_LOOK: begin
        if (kind_r == issp_pkg::KIND_INSERT) begin
          cl_we     = 1'b1;
          cl_addr   = key_r[4 +: CAW];
          cl_wdata  = cl_rdata | (16'd1 << key_r[3:0]);
          sm_we     = 1'b1;
          sm_addr   = key_r[8 +: SAW];
          sm_wdata  = sm_rdata | (16'd1 << key_r[7:4]);
          state_nxt = issp_pkg::ST_DONE;
        end else if (cw_m != '0) begin
          res_nxt.found  = 1'b1;
          res_nxt.answer = {key_r[7:4], issp_pkg::pick_bit(cw_m, succ)};
          state_nxt      = issp_pkg::ST_DONE;
        end else if (sw_m != '0) begin
          tc_nxt    = {key_r[15:8], issp_pkg::pick_bit(sw_m, succ)};
          cl_addr   = tc_nxt[CAW-1:0];
          state_nxt = issp_pkg::ST_TGT;
        end else if (succ ? (key_r[15:8] == LAST_WORD) : (key_r[15:8] == 8'd0)) begin
          state_nxt = issp_pkg::ST_DONE;
        end else begin
          w_nxt     = succ ? key_r[15:8] + 8'd1 : key_r[15:8] - 8'd1;
          sm_addr   = w_nxt[SAW-1:0];
          state_nxt = issp_pkg::ST_SUM;
        end
      end

      // scan further summary words one a cycle
      issp_pkg::ST_SUM: begin
        if (sm_rdata != '0) begin
          tc_nxt    = {w_r, issp_pkg::pick_bit(sm_rdata, succ)};
          cl_addr   = tc_nxt[CAW-1:0];
          state_nxt = issp_pkg::ST_TGT;
        end else if (succ ? (w_r == LAST_WORD) : (w_r == 8'd0)) begin
          state_nxt = issp_pkg::ST_DONE;
        end else begin
          w_nxt     = succ ? w_r + 8'd1 : w_r - 8'd1;
          sm_addr   = w_nxt[SAW-1:0];
          state_nxt = issp_pkg::ST_SUM;
        end
      end

      // target cluster word is here
      issp_pkg::ST_TGT: begin
        res_nxt.found  = 1'b1;
        res_nxt.answer = {tc_r[3:0], issp_pkg::pick_bit(cl_rdata, succ)};
        state_nxt      = issp_pkg::ST_DONE;
      end

      // hand the result to the output register
      issp_pkg::ST_DONE: begin
        res_valid = 1'b1;
        if (res_ready) begin
          state_nxt = issp_pkg::ST_IDLE;
        end
      end

      default: begin
        state_nxt = issp_pkg::ST_IDLE;
      end
    endcase
  end

  assign res_item = res_r;

endmodule
